[hdl/xmmd_pkg.sv]
// shared types, codes and helper function of the mmio mov decoder
package xmmd_pkg;

  // decode phases
  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_PREFIX = 3'd1;
  localparam logic [2:0] PH_OP2    = 3'd2;
  localparam logic [2:0] PH_MODRM  = 3'd3;
  localparam logic [2:0] PH_SIB    = 3'd4;
  localparam logic [2:0] PH_SKIP   = 3'd5;
  localparam logic [2:0] PH_IMM    = 3'd6;

  // result status codes
  localparam logic [2:0] ST_OK            = 3'd0;
  localparam logic [2:0] ST_PFX_AFTER_REX = 3'd1;
  localparam logic [2:0] ST_TOO_MANY_PFX  = 3'd2;
  localparam logic [2:0] ST_BAD_OPCODE    = 3'd3;
  localparam logic [2:0] ST_HIGH_BYTE     = 3'd4;
  localparam logic [2:0] ST_REG_FORM      = 3'd5;
  localparam logic [2:0] ST_TOO_LONG      = 3'd6;

  // longest instruction accepted, in bytes
  localparam logic [4:0] MAX_INSTR_LEN = 5'd15;

  // prefix and opcode bytes
  localparam logic [7:0] PFX_OPSZ  = 8'h66;
  localparam logic [7:0] PFX_FS    = 8'h64;
  localparam logic [7:0] PFX_GS    = 8'h65;
  localparam logic [7:0] PFX_ADSZ  = 8'h67;
  localparam logic [3:0] PFX_REX   = 4'h4;
  localparam logic [7:0] OP_ST8    = 8'h88;
  localparam logic [7:0] OP_ST     = 8'h89;
  localparam logic [7:0] OP_LD8    = 8'h8A;
  localparam logic [7:0] OP_LD     = 8'h8B;
  localparam logic [7:0] OP_ESC    = 8'h0F;
  localparam logic [7:0] OP_ST_IMM = 8'hC7;
  localparam logic [7:0] OP_MOVZX8 = 8'hB6;
  localparam logic [7:0] OP_MOVZX16 = 8'hB7;

  typedef struct packed {
    logic opsz;
    logic rex;
    logic rexw;
    logic rexr;
  } flags_t;

  typedef struct packed {
    logic [2:0]  phase;
    logic [3:0]  byte_count;
    flags_t      flags;
    logic [7:0]  opcode;
    logic [7:0]  modrm;
    logic [2:0]  skip_left;
    logic [31:0] imm_accum;
    logic [2:0]  imm_left;
    logic [63:0] addr;
  } state_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        is_write;
    logic [3:0]  mem_bytes;
    logic [3:0]  reg_index;
    logic [3:0]  dest_bytes;
    logic        uses_immediate;
    logic [63:0] immediate;
    logic [3:0]  instr_length;
    logic [63:0] fault_addr;
  } result_t;

  function automatic logic [3:0] access_bytes(input logic [7:0] op, input flags_t fl);
    logic [3:0] sz;
    if (op == OP_ST8 || op == OP_LD8 || op == OP_MOVZX8) sz = 4'd1;
    else if (op == OP_MOVZX16) sz = 4'd2;
    else if (fl.rexw) sz = 4'd8;
    else if (fl.opsz) sz = 4'd2;
    else sz = 4'd4;
    return sz;
  endfunction

endpackage

[hdl/xmmd_in_if.sv]
// input channel: one instruction byte per transaction
interface xmmd_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  instr_byte;
  logic        first_byte;
  logic [63:0] guest_addr;

  modport source (output valid, output instr_byte, output first_byte, output guest_addr,
                  input ready);
  modport sink (input valid, input instr_byte, input first_byte, input guest_addr,
                output ready);
endinterface

[hdl/xmmd_out_if.sv]
// result channel: one decoded access per transaction
interface xmmd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        is_write;
  logic [3:0]  mem_bytes;
  logic [3:0]  reg_index;
  logic [3:0]  dest_bytes;
  logic        uses_immediate;
  logic [63:0] immediate;
  logic [3:0]  instr_length;
  logic [63:0] fault_addr;

  modport source (output valid, output status, output is_write, output mem_bytes,
                  output reg_index, output dest_bytes, output uses_immediate,
                  output immediate, output instr_length, output fault_addr,
                  input ready);
  modport sink (input valid, input status, input is_write, input mem_bytes,
                input reg_index, input dest_bytes, input uses_immediate,
                input immediate, input instr_length, input fault_addr,
                output ready);
endinterface

[hdl/xmmd_step.sv]
// per-byte decode step: next decoder state and the result it may produce
module xmmd_step (
  input  xmmd_pkg::state_t  cur,
  input  logic [7:0]        instr_byte,
  input  logic              first_byte,
  input  logic [63:0]       guest_addr,
  output xmmd_pkg::state_t  nxt,
  output logic              emit,
  output xmmd_pkg::result_t res
);

  xmmd_pkg::state_t s;
  logic [2:0]  status;
  logic [4:0]  pos;
  logic        is_pfx;
  logic        go_adv;
  logic [1:0]  mod_f;
  logic [2:0]  rm_f;
  logic [2:0]  reg_f;
  logic [1:0]  imm_idx;
  logic [2:0]  imm_width;
  logic        wr;
  logic        use_imm;
  logic [3:0]  ms;

  assign mod_f = instr_byte[7:6];
  assign reg_f = instr_byte[5:3];
  assign rm_f  = instr_byte[2:0];
  assign is_pfx = (instr_byte == xmmd_pkg::PFX_OPSZ) || (instr_byte == xmmd_pkg::PFX_FS) ||
                  (instr_byte == xmmd_pkg::PFX_GS) || (instr_byte == xmmd_pkg::PFX_ADSZ) ||
                  (instr_byte[7:4] == xmmd_pkg::PFX_REX);

  always_comb begin
    s = cur;
    if (first_byte) begin
      s       = '0;
      s.addr  = guest_addr;
      s.phase = xmmd_pkg::PH_PREFIX;
    end
    nxt       = s;
    emit      = 1'b0;
    status    = xmmd_pkg::ST_OK;
    go_adv    = 1'b0;
    pos       = {1'b0, s.byte_count};
    imm_width = s.flags.opsz ? 3'd2 : 3'd4;
    imm_idx   = 2'(imm_width - s.imm_left);
    if (s.phase != xmmd_pkg::PH_IDLE) begin
      nxt.byte_count = s.byte_count + 4'd1;
      case (s.phase)
        xmmd_pkg::PH_PREFIX: begin
          if (is_pfx) begin
            if (s.flags.rex) begin
              emit   = 1'b1;
              status = xmmd_pkg::ST_PFX_AFTER_REX;
            end else begin
              if (instr_byte == xmmd_pkg::PFX_OPSZ) nxt.flags.opsz = 1'b1;
              if (instr_byte[7:4] == xmmd_pkg::PFX_REX) begin
                nxt.flags.rex  = 1'b1;
                nxt.flags.rexw = instr_byte[3];
                nxt.flags.rexr = instr_byte[2];
              end
              if (pos + 5'd1 >= xmmd_pkg::MAX_INSTR_LEN) begin
                emit   = 1'b1;
                status = xmmd_pkg::ST_TOO_MANY_PFX;
              end
            end
          end else if (pos + 5'd2 > xmmd_pkg::MAX_INSTR_LEN) begin
            emit   = 1'b1;
            status = xmmd_pkg::ST_TOO_MANY_PFX;
          end else if (instr_byte == xmmd_pkg::OP_ESC) begin
            nxt.phase = xmmd_pkg::PH_OP2;
          end else if (instr_byte == xmmd_pkg::OP_ST8 || instr_byte == xmmd_pkg::OP_ST ||
                       instr_byte == xmmd_pkg::OP_LD8 || instr_byte == xmmd_pkg::OP_LD ||
                       instr_byte == xmmd_pkg::OP_ST_IMM) begin
            nxt.opcode = instr_byte;
            nxt.phase  = xmmd_pkg::PH_MODRM;
          end else begin
            emit   = 1'b1;
            status = xmmd_pkg::ST_BAD_OPCODE;
          end
        end
        xmmd_pkg::PH_OP2: begin
          if (instr_byte == xmmd_pkg::OP_MOVZX8 || instr_byte == xmmd_pkg::OP_MOVZX16) begin
            nxt.opcode = instr_byte;
            nxt.phase  = xmmd_pkg::PH_MODRM;
          end else begin
            emit   = 1'b1;
            status = xmmd_pkg::ST_BAD_OPCODE;
          end
        end
        xmmd_pkg::PH_MODRM: begin
          nxt.modrm = instr_byte;
          // byte register 4..7 without rex names ah/ch/dh/bh
          if (xmmd_pkg::access_bytes(s.opcode, s.flags) == 4'd1 && reg_f > 3'd3 &&
              !s.flags.rex && s.opcode != xmmd_pkg::OP_MOVZX8) begin
            emit   = 1'b1;
            status = xmmd_pkg::ST_HIGH_BYTE;
          end else if (mod_f == 2'd3) begin
            emit   = 1'b1;
            status = xmmd_pkg::ST_REG_FORM;
          end else begin
            if (mod_f == 2'd2 || (mod_f == 2'd0 && rm_f == 3'd5)) nxt.skip_left = 3'd4;
            else if (mod_f == 2'd1) nxt.skip_left = 3'd1;
            else nxt.skip_left = 3'd0;
            if (s.opcode == xmmd_pkg::OP_ST_IMM) nxt.imm_left = imm_width;
            if (rm_f == 3'd4) nxt.phase = xmmd_pkg::PH_SIB;
            else go_adv = 1'b1;
          end
        end
        xmmd_pkg::PH_SIB: begin
          // no base with mod 0 means a 32-bit displacement follows
          if (s.modrm[7:6] == 2'd0 && rm_f == 3'd5) nxt.skip_left = 3'd4;
          go_adv = 1'b1;
        end
        xmmd_pkg::PH_SKIP: begin
          nxt.skip_left = s.skip_left - 3'd1;
          go_adv = 1'b1;
        end
        xmmd_pkg::PH_IMM: begin
          case (imm_idx)
            2'd0:    nxt.imm_accum = s.imm_accum | {24'd0, instr_byte};
            2'd1:    nxt.imm_accum = s.imm_accum | {16'd0, instr_byte, 8'd0};
            2'd2:    nxt.imm_accum = s.imm_accum | {8'd0, instr_byte, 16'd0};
            default: nxt.imm_accum = s.imm_accum | {instr_byte, 24'd0};
          endcase
          nxt.imm_left = s.imm_left - 3'd1;
          go_adv = 1'b1;
        end
        default: begin
          nxt.phase = xmmd_pkg::PH_IDLE;
        end
      endcase
      if (go_adv) begin
        if (nxt.skip_left != 3'd0) nxt.phase = xmmd_pkg::PH_SKIP;
        else if (nxt.imm_left != 3'd0) nxt.phase = xmmd_pkg::PH_IMM;
        else emit = 1'b1;
      end
      if (!emit && nxt.phase != xmmd_pkg::PH_IDLE &&
          {1'b0, nxt.byte_count} >= xmmd_pkg::MAX_INSTR_LEN) begin
        emit   = 1'b1;
        status = xmmd_pkg::ST_TOO_LONG;
      end
      if (emit) nxt.phase = xmmd_pkg::PH_IDLE;
    end
  end

  assign wr = (nxt.opcode == xmmd_pkg::OP_ST8) || (nxt.opcode == xmmd_pkg::OP_ST) ||
              (nxt.opcode == xmmd_pkg::OP_ST_IMM);
  assign use_imm = (nxt.opcode == xmmd_pkg::OP_ST_IMM);
  assign ms = xmmd_pkg::access_bytes(nxt.opcode, nxt.flags);

  always_comb begin
    res            = '0;
    res.status     = status;
    res.fault_addr = nxt.addr;
    if (status == xmmd_pkg::ST_OK) begin
      res.is_write       = wr;
      res.mem_bytes      = ms;
      res.reg_index      = use_imm ? 4'd0 : {nxt.flags.rexr, nxt.modrm[5:3]};
      res.uses_immediate = use_imm;
      res.instr_length   = nxt.byte_count;
      if (!wr) begin
        if (nxt.opcode == xmmd_pkg::OP_MOVZX8)
          res.dest_bytes = (nxt.flags.opsz && !nxt.flags.rexw) ? 4'd2 : 4'd8;
        else if (nxt.opcode == xmmd_pkg::OP_MOVZX16)
          res.dest_bytes = (nxt.flags.opsz && !nxt.flags.rexw) ? 4'd2 : 4'd8;
        else
          res.dest_bytes = (ms == 4'd4) ? 4'd8 : ms;
      end
      if (use_imm) begin
        if (nxt.flags.opsz)
          res.immediate = {{48{nxt.imm_accum[15]}}, nxt.imm_accum[15:0]};
        else
          res.immediate = {{32{nxt.imm_accum[31]}}, nxt.imm_accum};
      end
    end
  end

endmodule

[hdl/x86_mmio_mov_decoder_core.sv]
// top level of the byte-serial mmio mov / movzx instruction decoder
//
//  channel | direction | transaction carries
//  in_chan | sink      | instr_byte, first_byte, guest_addr
//  out_chan| source    | status, is_write, mem_bytes, reg_index, dest_bytes,
//          |           | uses_immediate, immediate, instr_length, fault_addr
//
// one byte per cycle while in_chan.ready is high: each byte passes through the decode
// step into the state and result registers in the cycle it is accepted, so a result
// appears in the cycle after the byte that completes or rejects the instruction
// in_chan.ready is high while the result register is empty or being drained
// a stall on out_chan holds the result register and stalls the input after it fills
// rst_n (synchronous) returns the decoder to idle and drops any pending result
module x86_mmio_mov_decoder_core (
  input  logic              clk,
  input  logic              rst_n,
  xmmd_in_if.sink           in_chan,
  xmmd_out_if.source        out_chan
);

  xmmd_pkg::state_t  state_r;
  xmmd_pkg::state_t  state_nxt;
  xmmd_pkg::result_t res_r;
  xmmd_pkg::result_t step_res;
  logic              step_emit;
  logic              out_valid_r;
  logic              in_acc;

  xmmd_step u_step (
    .cur        (state_r),
    .instr_byte (in_chan.instr_byte),
    .first_byte (in_chan.first_byte),
    .guest_addr (in_chan.guest_addr),
    .nxt        (state_nxt),
    .emit       (step_emit),
    .res        (step_res)
  );

  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign in_acc        = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) state_r <= state_nxt;
      if (in_acc && step_emit) out_valid_r <= 1'b1;
      else if (out_chan.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && step_emit) res_r <= step_res;
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.status         = res_r.status;
  assign out_chan.is_write       = res_r.is_write;
  assign out_chan.mem_bytes      = res_r.mem_bytes;
  assign out_chan.reg_index      = res_r.reg_index;
  assign out_chan.dest_bytes     = res_r.dest_bytes;
  assign out_chan.uses_immediate = res_r.uses_immediate;
  assign out_chan.immediate      = res_r.immediate;
  assign out_chan.instr_length   = res_r.instr_length;
  assign out_chan.fault_addr     = res_r.fault_addr;

  // a stray byte while idle changes nothing
  a_idle_ignore: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !in_chan.first_byte && state_r.phase == xmmd_pkg::PH_IDLE)
    |=> state_r.phase == xmmd_pkg::PH_IDLE)
    else $error("byte accepted while idle left the idle phase");

  // a good decode reports a legal access size and a sane length
  a_ok_size: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.status == xmmd_pkg::ST_OK)
    |-> ((res_r.mem_bytes == 4'd1 || res_r.mem_bytes == 4'd2 || res_r.mem_bytes == 4'd4 ||
          res_r.mem_bytes == 4'd8) && res_r.instr_length >= 4'd2 &&
         {1'b0, res_r.instr_length} <= xmmd_pkg::MAX_INSTR_LEN))
    else $error("decoded access has a bad size or length");

  // an error result carries only status and address
  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.status != xmmd_pkg::ST_OK)
    |-> (!res_r.is_write && res_r.mem_bytes == 4'd0 && res_r.immediate == 64'd0 &&
         res_r.instr_length == 4'd0 && !res_r.uses_immediate))
    else $error("error result carries decode fields");

  // stores never clear a destination register
  a_store_dest: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.is_write) |-> res_r.dest_bytes == 4'd0)
    else $error("store result with nonzero destination width");

endmodule
